// File: src/knmd_pkg.sv
// ----------------------------------------------------------------------------
// knmd_pkg
// shared widths and types for the k-nearest mean distance score block
// ----------------------------------------------------------------------------
package knmd_pkg;

    // depth of the sorted chain, upper bound on k
    localparam int MAX_K   = 16;
    // matrix order bound, sets index width
    localparam int MAX_N   = 1024;

    localparam int DIST_W  = 32;
    localparam int IDX_W   = $clog2(MAX_N);
    localparam int KCFG_W  = 5;
    localparam int KCNT_W  = $clog2(MAX_K + 1);
    localparam int SUM_W   = DIST_W + $clog2(MAX_K);
    localparam int DCNT_W  = $clog2(SUM_W);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: src/k_nearest_mean_distance_score.sv
// ----------------------------------------------------------------------------
// k_nearest_mean_distance_score
// per-row mean of the k smallest off-diagonal distances of a matrix stream
// ----------------------------------------------------------------------------
// usage
//   item channel: one matrix element per beat (distance, row_index,
//   col_index, last_in_row), accepted when item_valid is high and item_stall
//   is low. diagonal elements are not kept but may still end a row.
//   score channel: one beat per row end (row_score_index, score, too_few),
//   taken when score_valid is high and score_stall is low.
//   k_neighbors_we / k_neighbors_wdata write k; 0 acts as 1, above 16 as 16.
// throughput and row end
//   elements inside a row go in one per cycle: a chain of 16 cells does a
//   sorted insert of each accepted beat.
//   after the row end beat the chain shifts its k smallest values into an
//   adder, one per cycle, then a bit-serial divider forms the mean, the
//   control sees it finish and the result is loaded into the output
//   register, which raises score_valid.
//   item_stall is high over that span.
// reset
//   every cell holds all ones, the kept count is zero and k is 1.
// stall
//   a held score beat does not stop the next row from streaming in; only a
//   second row end keeps item_stall high until the output register is free.
// ----------------------------------------------------------------------------
module k_nearest_mean_distance_score (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           k_neighbors_we,
    input  logic [knmd_pkg::KCFG_W-1:0]    k_neighbors_wdata,

    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [knmd_pkg::DIST_W-1:0]    distance,
    input  logic [knmd_pkg::IDX_W-1:0]     row_index,
    input  logic [knmd_pkg::IDX_W-1:0]     col_index,
    input  logic                           last_in_row,

    output logic                           score_valid,
    input  logic                           score_stall,
    output logic [knmd_pkg::IDX_W-1:0]     row_score_index,
    output logic [knmd_pkg::DIST_W-1:0]    score,
    output logic                           too_few
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                          state_reg;
    logic [knmd_pkg::KCFG_W-1:0]     k_cfg_reg;
    logic [knmd_pkg::KCNT_W-1:0]     kept_reg;
    logic [knmd_pkg::KCNT_W-1:0]     k_eff_reg;
    logic [knmd_pkg::KCNT_W-1:0]     sum_cnt_reg;
    logic [knmd_pkg::SUM_W-1:0]      acc_reg;
    logic [knmd_pkg::IDX_W-1:0]      row_reg;
    logic                            few_reg;
    logic                            out_valid_reg;
    logic [knmd_pkg::IDX_W-1:0]      out_row_reg;
    logic [knmd_pkg::DIST_W-1:0]     out_score_reg;
    logic                            out_few_reg;

    logic                            item_acc;
    logic                            off_diag;
    logic [knmd_pkg::KCNT_W-1:0]     kept_next;
    logic [knmd_pkg::KCNT_W-1:0]     k_eff;
    logic                            sum_last;
    logic [knmd_pkg::SUM_W-1:0]      acc_next;
    logic                            out_free;
    logic                            load_out;
    knmd_pkg::cell_ctrl_t            ctrl;

    logic [knmd_pkg::DIST_W-1:0]     cell_val [knmd_pkg::MAX_K];
    logic                            cell_lt  [knmd_pkg::MAX_K];

    logic                            div_done;
    logic [knmd_pkg::DIST_W-1:0]     div_q;

    // new elements are taken only while no row end is in flight
    assign item_stall = state_reg != ST_IDLE;
    assign item_acc   = item_valid && !item_stall;
    assign off_diag   = col_index != row_index;

    // kept count saturates at the chain depth
    always_comb
    begin
        kept_next = kept_reg;
        if (item_acc && off_diag && (kept_reg != knmd_pkg::KCNT_W'(knmd_pkg::MAX_K)))
        begin
            kept_next = kept_reg + knmd_pkg::KCNT_W'(1);
        end
    end

    // clamp k into 1..MAX_K
    always_comb
    begin
        if (k_cfg_reg == '0)
        begin
            k_eff = knmd_pkg::KCNT_W'(1);
        end
        else if (int'(k_cfg_reg) > knmd_pkg::MAX_K)
        begin
            k_eff = knmd_pkg::KCNT_W'(knmd_pkg::MAX_K);
        end
        else
        begin
            k_eff = knmd_pkg::KCNT_W'(k_cfg_reg);
        end
    end

    // summing: head of the chain feeds the adder while the chain shifts down
    assign sum_last = (sum_cnt_reg + knmd_pkg::KCNT_W'(1)) == k_eff_reg;
    assign acc_next = acc_reg + knmd_pkg::SUM_W'(cell_val[0]);

    always_comb
    begin
        ctrl.insert = item_acc && off_diag;
        ctrl.shift  = state_reg == ST_SUM;
        // chain returns to all ones once the last needed value is out
        ctrl.clear  = (state_reg == ST_SUM) && sum_last;
    end

    // sorted insertion chain, smallest value at cell 0
    for (genvar i = 0; i < knmd_pkg::MAX_K; i++)
    begin : g_cell
        logic [knmd_pkg::DIST_W-1:0] prev_v;
        logic                        prev_l;
        logic [knmd_pkg::DIST_W-1:0] next_v;

        if (i == 0)
        begin : g_head
            assign prev_v = knmd_pkg::DIST_MAX;
            assign prev_l = 1'b0;
        end
        else
        begin : g_body
            assign prev_v = cell_val[i-1];
            assign prev_l = cell_lt[i-1];
        end

        if (i == knmd_pkg::MAX_K - 1)
        begin : g_tail
            assign next_v = knmd_pkg::DIST_MAX;
        end
        else
        begin : g_link
            assign next_v = cell_val[i+1];
        end

        knmd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .din      (distance),
            .prev_val (prev_v),
            .prev_lt  (prev_l),
            .next_val (next_v),
            .val      (cell_val[i]),
            .lt       (cell_lt[i])
        );
    end

    knmd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.clear),
        .dividend (acc_next),
        .divisor  (k_eff_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // output register is free when empty or being taken at this edge
    assign out_free = !out_valid_reg || !score_stall;
    // finished row moves into the output register
    assign load_out = (state_reg == ST_HOLD) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_cfg_reg     <= knmd_pkg::KCFG_W'(1);
            kept_reg      <= '0;
            k_eff_reg     <= knmd_pkg::KCNT_W'(1);
            sum_cnt_reg   <= '0;
            acc_reg       <= '0;
            row_reg       <= '0;
            few_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_score_reg <= '0;
            out_few_reg   <= 1'b0;
        end
        else
        begin
            if (k_neighbors_we)
            begin
                k_cfg_reg <= k_neighbors_wdata;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !score_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    kept_reg <= kept_next;
                    if (item_acc && last_in_row)
                    begin
                        row_reg     <= row_index;
                        k_eff_reg   <= k_eff;
                        few_reg     <= kept_next < k_eff;
                        sum_cnt_reg <= '0;
                        acc_reg     <= '0;
                        state_reg   <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    acc_reg     <= acc_next;
                    sum_cnt_reg <= sum_cnt_reg + knmd_pkg::KCNT_W'(1);
                    if (sum_last)
                    begin
                        kept_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        out_row_reg   <= row_reg;
                        out_score_reg <= few_reg ? '0 : div_q;
                        out_few_reg   <= few_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign score_valid     = out_valid_reg;
    assign row_score_index = out_row_reg;
    assign score           = out_score_reg;
    assign too_few         = out_few_reg;

    // chain order check
    logic chain_sorted;
    always_comb
    begin
        chain_sorted = 1'b1;
        for (int i = 1; i < knmd_pkg::MAX_K; i++)
        begin
            if (cell_val[i] < cell_val[i-1])
            begin
                chain_sorted = 1'b0;
            end
        end
    end

    a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        chain_sorted)
        else $error("insertion chain out of order");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(kept_reg) <= knmd_pkg::MAX_K)
        else $error("kept count above chain depth");

    a_rise_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(score_valid) |-> $past(state_reg == ST_HOLD))
        else $error("score beat without a finished row");

    a_div_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (kept_reg == '0 && cell_val[0] == knmd_pkg::DIST_MAX))
        else $error("chain not cleared after summing");

endmodule

// File: src/knmd_cell.sv
// ----------------------------------------------------------------------------
// knmd_cell
// one slot of the sorted insertion chain
// ----------------------------------------------------------------------------
module knmd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  knmd_pkg::cell_ctrl_t           ctrl,
    input  logic [knmd_pkg::DIST_W-1:0]    din,
    input  logic [knmd_pkg::DIST_W-1:0]    prev_val,
    input  logic                           prev_lt,
    input  logic [knmd_pkg::DIST_W-1:0]    next_val,
    output logic [knmd_pkg::DIST_W-1:0]    val,
    output logic                           lt
);

    logic [knmd_pkg::DIST_W-1:0] val_reg;
    logic [knmd_pkg::DIST_W-1:0] val_next;

    // strict compare: equal values go behind
    assign lt  = din < val_reg;
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.clear)
        begin
            val_next = knmd_pkg::DIST_MAX;
        end
        else if (ctrl.shift)
        begin
            val_next = next_val;
        end
        else if (ctrl.insert && lt)
        begin
            // upstream taking the new value pushes its old one here
            val_next = prev_lt ? prev_val : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= knmd_pkg::DIST_MAX;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

endmodule

// File: src/knmd_divider.sv
// ----------------------------------------------------------------------------
// knmd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module knmd_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [knmd_pkg::SUM_W-1:0]     dividend,
    input  logic [knmd_pkg::KCNT_W-1:0]    divisor,
    output logic                           done,
    output logic [knmd_pkg::DIST_W-1:0]    quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [knmd_pkg::DCNT_W-1:0]   cnt_reg;
    logic [knmd_pkg::KCNT_W-1:0]   rem_reg;
    logic [knmd_pkg::SUM_W-1:0]    dvd_reg;

    logic [knmd_pkg::KCNT_W:0]     trial;
    logic [knmd_pkg::KCNT_W:0]     dsr_ext;
    logic                          q_bit;
    logic [knmd_pkg::KCNT_W-1:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[knmd_pkg::SUM_W-1]};
        dsr_ext  = {1'b0, divisor};
        q_bit    = trial >= dsr_ext;
        // remainder stays below the divisor, so it fits back
        rem_next = q_bit ? knmd_pkg::KCNT_W'(trial - dsr_ext)
                         : knmd_pkg::KCNT_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[knmd_pkg::SUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg + knmd_pkg::DCNT_W'(1);
                if (cnt_reg == knmd_pkg::DCNT_W'(knmd_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    // mean of values that fit the distance width fits it too
    assign quotient = dvd_reg[knmd_pkg::DIST_W-1:0];

endmodule

// File: sim/tb_k_nearest_mean_distance_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_nearest_mean_distance_score
// self-checking bench for the per-row k-nearest mean distance score block
// ----------------------------------------------------------------------------
// matrix rows are streamed into the block one element per beat. the bench
// keeps its own sorted list of the smallest off-diagonal distances of the
// open row and works out the score beat each row end must produce; every
// score beat is checked field by field against the oldest one still due.
// a short directed part hits the k and distance extremes, then random rows
// follow under several k settings, with idle and stall bursts on both sides
// and one long hold on the score side that backs the block up.
// ----------------------------------------------------------------------------
module tb_k_nearest_mean_distance_score;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 6;
    // time allowed from a row end to its score beat, with margin
    localparam int ROW_DRAIN_CYCLES = knmd_pkg::MAX_K + 48;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 10;
    localparam int RAND_PHASES      = 6;
    localparam int PHASE_ITEMS      = 74;
    // raw k values outside the meaningful range
    localparam int K_RAW_ZERO       = 0;
    localparam int K_RAW_TOP        = 31;

    typedef enum int {
        DS_WIDE,
        DS_TIES,
        DS_NEAR_MAX,
        DS_MIXED
    } dist_style_t;

    typedef struct packed {
        logic [knmd_pkg::DIST_W-1:0] dist_val;
        logic [knmd_pkg::IDX_W-1:0]  row;
        logic [knmd_pkg::IDX_W-1:0]  col;
        logic                        last;
    } matrix_elem_t;

    typedef struct packed {
        logic [knmd_pkg::IDX_W-1:0]  row;
        logic [knmd_pkg::DIST_W-1:0] score;
        logic                        few;
    } row_score_t;

    // ------------------------------------------------------------------------
    // dut connections, every input known from time zero
    // ------------------------------------------------------------------------
    logic                        clk               = 1'b0;
    logic                        rst_n             = 1'b0;
    logic                        k_neighbors_we    = 1'b0;
    logic [knmd_pkg::KCFG_W-1:0] k_neighbors_wdata = '0;
    logic                        item_valid        = 1'b0;
    logic                        item_stall;
    logic [knmd_pkg::DIST_W-1:0] distance          = '0;
    logic [knmd_pkg::IDX_W-1:0]  row_index         = '0;
    logic [knmd_pkg::IDX_W-1:0]  col_index         = '0;
    logic                        last_in_row       = 1'b0;
    logic                        score_valid;
    logic                        score_stall       = 1'b0;
    logic [knmd_pkg::IDX_W-1:0]  row_score_index;
    logic [knmd_pkg::DIST_W-1:0] score;
    logic                        too_few;

    k_nearest_mean_distance_score i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .k_neighbors_we    (k_neighbors_we),
        .k_neighbors_wdata (k_neighbors_wdata),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .distance          (distance),
        .row_index         (row_index),
        .col_index         (col_index),
        .last_in_row       (last_in_row),
        .score_valid       (score_valid),
        .score_stall       (score_stall),
        .row_score_index   (row_score_index),
        .score             (score),
        .too_few           (too_few)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // bench-side copy of the row state and of k
    // ------------------------------------------------------------------------
    logic [knmd_pkg::DIST_W-1:0] nearest_dist [knmd_pkg::MAX_K];
    int                          nearest_count;
    logic [knmd_pkg::KCFG_W-1:0] k_setting;

    matrix_elem_t      elems_pending [$];   // waiting for the driver
    row_score_t        scores_due [$];      // predicted, not yet seen

    // handshake and idling bookkeeping
    logic              item_beat = 1'b0;    // element taken at the last rising edge
    int                send_gap;
    int                stall_left;
    int                hold_left;
    int                long_hold_asks;
    int                long_hold_done;
    bit                send_idle_on;
    bit                recv_idle_on;
    int                quiet_cycles;

    // statistics
    int                elems_queued;
    int                elems_taken;
    int                scores_seen;
    int                few_seen;
    int                k_writes;
    int                fail_count;
    row_score_t        head_score;
    matrix_elem_t      next_elem;

    function automatic void clear_nearest();
        for (int i = 0; i < knmd_pkg::MAX_K; i++)
            nearest_dist[i] = knmd_pkg::DIST_MAX;
        nearest_count = 0;
    endfunction

    // one accepted element: sorted insert, and at a row end the score it owes
    task automatic absorb_element(input matrix_elem_t e);
        int          pos;
        int          k_eff;
        logic [63:0] sum;
        row_score_t  res;
        pos = 0;
        sum = '0;
        if (e.col != e.row)
        begin
            while (pos < nearest_count && nearest_dist[pos] <= e.dist_val)
                pos++;
            if (pos < knmd_pkg::MAX_K)
            begin
                for (int i = knmd_pkg::MAX_K - 1; i > pos; i--)
                    nearest_dist[i] = nearest_dist[i - 1];
                nearest_dist[pos] = e.dist_val;
            end
            if (nearest_count < knmd_pkg::MAX_K)
                nearest_count++;
        end
        if (e.last)
        begin
            // out-of-range k is clamped into 1..MAX_K
            k_eff = (k_setting == 0) ? 1 :
                    (k_setting > knmd_pkg::MAX_K) ? knmd_pkg::MAX_K : int'(k_setting);
            res.row = e.row;
            if (nearest_count < k_eff)
            begin
                res.score = '0;
                res.few   = 1'b1;
            end
            else
            begin
                for (int i = 0; i < k_eff; i++)
                    sum += nearest_dist[i];
                res.score = knmd_pkg::DIST_W'(sum / k_eff);
                res.few   = 1'b0;
            end
            scores_due.insert(scores_due.size(), res);
            clear_nearest();
        end
    endtask

    // ------------------------------------------------------------------------
    // rising edge: take element beats into the predictor, check score beats,
    // and watch for a stuck handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_beat <= 1'b0;
        end
        else
        begin
            item_beat <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                absorb_element({distance, row_index, col_index, last_in_row});
                elems_taken++;
            end
            if (score_valid && !score_stall)
            begin
                scores_seen++;
                if (too_few)
                    few_seen++;
                if (scores_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] score beat with none due: row %0d score %h too_few %b",
                                 $realtime, row_score_index, score, too_few);
                end
                else
                begin
                    head_score = scores_due.pop_front();
                    if (head_score.row !== row_score_index || head_score.score !== score
                        || head_score.few !== too_few)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] mismatch: row %0d/%0d score %h/%h few %b/%b",
                                     $realtime, head_score.row, row_score_index,
                                     head_score.score, score, head_score.few, too_few);
                    end
                end
            end
            // any beat on either side resets the watchdog
            if ((item_valid && !item_stall) || (score_valid && !score_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d scores still due",
                         $realtime, quiet_cycles, scores_due.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // element driver: moves on once the held beat was taken, random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_beat))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (elems_pending.size() == 0)
            begin
                item_valid <= 1'b0;
            end
            else if (send_idle_on && $urandom_range(0, 11) == 0)
            begin
                // gap burst of random length, this one included
                send_gap = $urandom_range(1, 11) - 1;
                item_valid <= 1'b0;
            end
            else
            begin
                next_elem = elems_pending.pop_front();
                distance    <= next_elem.dist_val;
                row_index   <= next_elem.row;
                col_index   <= next_elem.col;
                last_in_row <= next_elem.last;
                item_valid  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // score receiver: long hold on request, otherwise random stall bursts
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_asks != long_hold_done && hold_left == 0)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                score_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                score_stall <= 1'b1;
            end
            else if (recv_idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                score_stall <= 1'b1;
            end
            else
            begin
                score_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_elem(input logic [knmd_pkg::DIST_W-1:0] d,
                              input logic [knmd_pkg::IDX_W-1:0] r,
                              input logic [knmd_pkg::IDX_W-1:0] c, input logic last);
        matrix_elem_t e;
        e = {d, r, c, last};
        elems_pending.insert(elems_pending.size(), e);
        elems_queued++;
    endtask

    function automatic logic [knmd_pkg::DIST_W-1:0] pick_distance(input dist_style_t style);
        case (style)
            DS_WIDE:     return $urandom;
            DS_TIES:     return knmd_pkg::DIST_W'($urandom_range(0, 7));
            DS_NEAR_MAX: return knmd_pkg::DIST_MAX - knmd_pkg::DIST_W'($urandom_range(0, 7));
            default:
            begin
                if ($urandom_range(0, 1))
                    return $urandom;
                return $urandom_range(0, 1) ? knmd_pkg::DIST_MAX : '0;
            end
        endcase
    endfunction

    // a well-formed row over consecutive columns, the diagonal among them
    // most of the time, sometimes as the element that ends the row
    task automatic queue_random_row();
        int                         n;
        int                         base;
        bit                         diag_last;
        dist_style_t                style;
        logic [knmd_pkg::IDX_W-1:0] r;
        if ($urandom_range(0, (k_setting > 8) ? 1 : 7) == 0)
            n = $urandom_range(knmd_pkg::MAX_K + 1, knmd_pkg::MAX_K + 8);
        else
            n = $urandom_range(1, 14);
        base = $urandom_range(0, knmd_pkg::MAX_N - n);
        if ($urandom_range(0, 2) == 0)
            r = knmd_pkg::IDX_W'($urandom_range(0, knmd_pkg::MAX_N - 1));
        else
            r = knmd_pkg::IDX_W'(base + $urandom_range(0, n - 1));
        style     = dist_style_t'($urandom_range(0, 3));
        diag_last = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++)
            queue_elem(pick_distance(style), r,
                       (diag_last && i == n - 1) ? r : knmd_pkg::IDX_W'(base + i),
                       i == n - 1);
    endtask

    // mostly rows, with stray elements whose row, column and end mark are random
    task automatic queue_random_phase(input int items);
        int stop_at;
        stop_at = elems_queued + items;
        while (elems_queued < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_elem($urandom, knmd_pkg::IDX_W'($urandom), knmd_pkg::IDX_W'($urandom),
                           1'($urandom));
            else
                queue_random_row();
        end
        // a phase always closes a row so that k changes between rows only
        queue_random_row();
    endtask

    task automatic wait_all_scored();
        while (elems_pending.size() != 0 || item_valid || scores_due.size() != 0)
            @(posedge clk);
        repeat (ROW_DRAIN_CYCLES) @(posedge clk);
    endtask

    // k is written only with nothing in flight
    task automatic write_k(input int value);
        wait_all_scored();
        @(negedge clk);
        k_neighbors_we    <= 1'b1;
        k_neighbors_wdata <= knmd_pkg::KCFG_W'(value);
        k_setting = knmd_pkg::KCFG_W'(value);
        k_writes++;
        @(negedge clk);
        k_neighbors_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_nearest();
        k_setting    = knmd_pkg::KCFG_W'(1);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part, k still at its reset value of one ---
        // diagonal element alone ends the row: nothing kept, flagged
        queue_elem(32'h1234_5678, knmd_pkg::IDX_W'(5), knmd_pkg::IDX_W'(5), 1'b1);
        // row index moves without an end mark, diagonal of row 0 skipped
        queue_elem(32'd9, '0, knmd_pkg::IDX_W'(1), 1'b0);
        queue_elem(32'd7, '0, '0, 1'b0);
        queue_elem(32'd3, '1, knmd_pkg::IDX_W'(2), 1'b1);

        // widest sum: sixteen all-ones distances average back to all ones
        write_k(knmd_pkg::MAX_K);
        for (int i = 0; i < knmd_pkg::MAX_K; i++)
            queue_elem(knmd_pkg::DIST_MAX, '1, knmd_pkg::IDX_W'(i), i == knmd_pkg::MAX_K - 1);

        // k of zero acts as one; a diagonal element ends the row
        write_k(K_RAW_ZERO);
        queue_elem(knmd_pkg::DIST_MAX, knmd_pkg::IDX_W'(2), '1, 1'b0);
        queue_elem('0, knmd_pkg::IDX_W'(2), knmd_pkg::IDX_W'(2), 1'b1);

        // raw k above the chain depth is clamped, one value is too few
        write_k(K_RAW_TOP);
        queue_elem('0, knmd_pkg::IDX_W'(7), knmd_pkg::IDX_W'(8), 1'b1);

        // --- random part under several k settings ---
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       write_k(2);
                1:       write_k(knmd_pkg::MAX_K);
                2:       write_k($urandom_range(3, knmd_pkg::MAX_K - 1));
                3:       write_k(1);
                4:       write_k($urandom_range(K_RAW_ZERO, K_RAW_TOP));
                default: write_k(8);
            endcase
            // the closing phase runs with no idling at all
            send_idle_on = (ph != RAND_PHASES - 1) && (ph % 3 != 1);
            recv_idle_on = (ph != RAND_PHASES - 1) && (ph % 3 != 2);
            queue_random_phase(PHASE_ITEMS);
            // hold the score side off while rows keep coming, so the output
            // register stays full and the item side backs up
            if (ph == 0)
                long_hold_asks++;
        end

        wait_all_scored();
        if (scores_due.size() != 0)
        begin
            fail_count++;
            $display("%0d predicted scores never arrived", scores_due.size());
        end
        $display("covered %0d matrix elements and %0d row scores, %0d of them flagged too_few",
                 elems_taken, scores_seen, few_seen);
        $display("%0d k writes (0, 1, 16 and 31 among them), %0d long score hold, %0d failures",
                 k_writes, long_hold_done, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
